[design/abb_pkg.sv]
// ----------------------------------------------------------------------------
// abb_pkg: shared types and constants for the alpha bounding box core
// Frame size limits, field widths, register indexes and the structs that
// travel between the core's submodules.
// ----------------------------------------------------------------------------
package abb_pkg;

    // Largest frame dimension and the widths that follow from it
    localparam int unsigned MAX_DIM    = 4096;
    localparam int unsigned DIM_W      = $clog2(MAX_DIM);
    localparam int unsigned CFG_DIM_W  = DIM_W + 1;
    localparam int unsigned ALPHA_W    = 8;
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = CFG_DIM_W;
    localparam int unsigned BOX_W      = 4 * DIM_W;

    // Register reset values
    localparam logic [ALPHA_W-1:0]   THRESHOLD_RST = ALPHA_W'(8);
    localparam logic [CFG_DIM_W-1:0] DIM_RST       = CFG_DIM_W'(MAX_DIM);

    // Register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ALPHA_THRESHOLD = 2'd0,
        REG_FRAME_WIDTH     = 2'd1,
        REG_FRAME_HEIGHT    = 2'd2
    } abb_reg_idx_t;

    // Configuration as seen by the tracker
    typedef struct packed {
        logic [ALPHA_W-1:0]   alpha_threshold;
        logic [CFG_DIM_W-1:0] frame_width;
        logic [CFG_DIM_W-1:0] frame_height;
    } abb_cfg_t;

    // One result transaction
    typedef struct packed {
        logic             any_visible;
        logic [DIM_W-1:0] bottom_row;
        logic [DIM_W-1:0] right_col;
        logic [DIM_W-1:0] top_row;
        logic [DIM_W-1:0] left_col;
    } abb_box_t;

    // Effective dimension minus one: zero acts as one, oversize clamps
    function automatic logic [DIM_W-1:0] dim_last(input logic [CFG_DIM_W-1:0] dim);
        logic [DIM_W-1:0] last;
        if (dim == '0) begin
            last = '0;
        end else if (dim >= CFG_DIM_W'(MAX_DIM)) begin
            last = DIM_W'(MAX_DIM - 1);
        end else begin
            last = dim[DIM_W-1:0] - DIM_W'(1);
        end
        return last;
    endfunction

endpackage

[design/abb_in_reg.sv]
// ----------------------------------------------------------------------------
// abb_in_reg: input register
// Holds one pixel transaction; refills in the same cycle the tracker
// consumes the held pixel.
// ----------------------------------------------------------------------------
module abb_in_reg
    import abb_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [ALPHA_W-1:0] s_tdata,    // [7:0] pixel_alpha
    input  logic               pop,
    output logic               item_valid,
    output logic [ALPHA_W-1:0] item_alpha
);

    logic               valid_reg;
    logic               valid_next;
    logic [ALPHA_W-1:0] alpha_reg;

    assign s_tready   = !valid_reg || pop;
    assign valid_next = s_tvalid || (valid_reg && !pop);

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= valid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            alpha_reg <= s_tdata;
        end
    end

    assign item_valid = valid_reg;
    assign item_alpha = alpha_reg;

endmodule

[design/abb_box_track.sv]
// ----------------------------------------------------------------------------
// abb_box_track: raster position and bounding box tracker
// Counts column and row, folds each visible pixel into the box and builds
// the result on the last pixel of a frame.
// ----------------------------------------------------------------------------
module abb_box_track
    import abb_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  abb_cfg_t           cfg,
    input  logic               item_valid,
    input  logic [ALPHA_W-1:0] item_alpha,
    input  logic               out_free,
    output logic               step,
    output logic               res_valid,
    output abb_box_t           res
);

    logic [DIM_W-1:0] col_reg, col_next;
    logic [DIM_W-1:0] row_reg, row_next;
    logic             seen_reg, seen_next;
    logic [DIM_W-1:0] min_col_reg, min_col_next;
    logic [DIM_W-1:0] min_row_reg, min_row_next;
    logic [DIM_W-1:0] max_col_reg, max_col_next;
    logic [DIM_W-1:0] max_row_reg, max_row_next;

    logic [DIM_W-1:0] col_last;
    logic [DIM_W-1:0] row_last;
    logic             row_end;
    logic             frame_end;
    logic             visible;

    // Frame geometry
    assign col_last  = dim_last(cfg.frame_width);
    assign row_last  = dim_last(cfg.frame_height);
    assign row_end   = col_reg >= col_last;
    assign frame_end = row_end && (row_reg >= row_last);
    assign visible   = item_alpha > cfg.alpha_threshold;

    // A frame end needs room in the output register
    assign step      = item_valid && (!frame_end || out_free);
    assign res_valid = step && frame_end;

    // Box update for the current pixel
    always_comb begin
        seen_next    = seen_reg;
        min_col_next = min_col_reg;
        min_row_next = min_row_reg;
        max_col_next = max_col_reg;
        max_row_next = max_row_reg;
        if (visible) begin
            seen_next = 1'b1;
            if (!seen_reg) begin
                min_col_next = col_reg;
                max_col_next = col_reg;
                min_row_next = row_reg;
                max_row_next = row_reg;
            end else begin
                if (col_reg < min_col_reg) min_col_next = col_reg;
                if (col_reg > max_col_reg) max_col_next = col_reg;
                if (row_reg < min_row_reg) min_row_next = row_reg;
                if (row_reg > max_row_reg) max_row_next = row_reg;
            end
        end
    end

    // Position update
    always_comb begin
        if (row_end) begin
            col_next = '0;
            row_next = row_reg + DIM_W'(1);
        end else begin
            col_next = col_reg + DIM_W'(1);
            row_next = row_reg;
        end
    end

    // Result: full frame when nothing was visible
    always_comb begin
        if (seen_next) begin
            res.left_col    = min_col_next;
            res.top_row     = min_row_next;
            res.right_col   = max_col_next;
            res.bottom_row  = max_row_next;
            res.any_visible = 1'b1;
        end else begin
            res.left_col    = '0;
            res.top_row     = '0;
            res.right_col   = col_last;
            res.bottom_row  = row_last;
            res.any_visible = 1'b0;
        end
    end

    // Frame state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            seen_reg    <= 1'b0;
            min_col_reg <= '0;
            min_row_reg <= '0;
            max_col_reg <= '0;
            max_row_reg <= '0;
        end else if (step) begin
            if (frame_end) begin
                col_reg     <= '0;
                row_reg     <= '0;
                seen_reg    <= 1'b0;
                min_col_reg <= '0;
                min_row_reg <= '0;
                max_col_reg <= '0;
                max_row_reg <= '0;
            end else begin
                col_reg     <= col_next;
                row_reg     <= row_next;
                seen_reg    <= seen_next;
                min_col_reg <= min_col_next;
                min_row_reg <= min_row_next;
                max_col_reg <= max_col_next;
                max_row_reg <= max_row_next;
            end
        end
    end

    // Box stays empty until a visible pixel arrives
    a_empty_box: assert property (@(posedge aclk) disable iff (!aresetn)
        !seen_reg |-> (min_col_reg == '0 && max_col_reg == '0 &&
                       min_row_reg == '0 && max_row_reg == '0))
        else $error("box registers changed without a visible pixel");

    // Box corners stay ordered
    a_box_order: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg |-> (min_col_reg <= max_col_reg && min_row_reg <= max_row_reg))
        else $error("bounding box corners out of order");

    // Frame end clears the frame state
    a_frame_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |=> (col_reg == '0 && row_reg == '0 && !seen_reg))
        else $error("frame state not cleared after frame end");

endmodule

[design/abb_out_reg.sv]
// ----------------------------------------------------------------------------
// abb_out_reg: result register
// Holds one box transaction until the sink takes it.
// ----------------------------------------------------------------------------
module abb_out_reg
    import abb_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  abb_box_t         res,
    output logic             out_free,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [BOX_W-1:0] m_tdata,    // [11:0] left_col, [23:12] top_row,
                                         // [35:24] right_col, [47:36] bottom_row
    output logic             m_tuser     // [0] any_visible
);

    logic     valid_reg;
    abb_box_t box_reg;

    assign out_free = !valid_reg || m_tready;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (out_free) begin
            valid_reg <= load;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (load) begin
            box_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {box_reg.bottom_row, box_reg.right_col,
                       box_reg.top_row, box_reg.left_col};
    assign m_tuser  = box_reg.any_visible;

endmodule

[design/alpha_bounding_box_core.sv]
// ----------------------------------------------------------------------------
// alpha_bounding_box_core: bounding box of the opaque pixels of a frame
// Pixel alphas arrive in raster order; one box transaction leaves per frame.
// ----------------------------------------------------------------------------
// The core takes one pixel per clock, with no gaps between frames, while the input side is not stalled.
// A pixel is folded into the box by the tracker's compare-and-select stage
// during the cycle it sits in the input register; the box of a frame is
// loaded into the output register when the tracker consumes its last pixel.
// The input side stalls only when a frame's result is still held unaccepted
// in the output register as the next frame's last pixel reaches the tracker.
// Write the registers only while no pixel transaction is in flight; a size
// change takes effect at once, even within a frame. A size of zero acts
// as one and a size above 4096 acts as 4096. With no visible pixel the full
// frame is reported with any_visible low.
module alpha_bounding_box_core
    import abb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    // pixel stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [ALPHA_W-1:0]    s_tdata,     // [7:0] pixel_alpha
    // box stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [BOX_W-1:0]      m_tdata,     // [11:0] left_col, [23:12] top_row,
                                               // [35:24] right_col, [47:36] bottom_row
    output logic                  m_tuser      // [0] any_visible
);

    abb_cfg_t           cfg_reg;
    logic               item_valid;
    logic [ALPHA_W-1:0] item_alpha;
    logic               step;
    logic               res_valid;
    logic               out_free;
    abb_box_t           res;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.alpha_threshold <= THRESHOLD_RST;
            cfg_reg.frame_width     <= DIM_RST;
            cfg_reg.frame_height    <= DIM_RST;
        end else if (cfg_wr_en) begin
            case (abb_reg_idx_t'(cfg_addr))
                REG_ALPHA_THRESHOLD: cfg_reg.alpha_threshold <= cfg_wr_data[ALPHA_W-1:0];
                REG_FRAME_WIDTH:     cfg_reg.frame_width     <= cfg_wr_data[CFG_DIM_W-1:0];
                REG_FRAME_HEIGHT:    cfg_reg.frame_height    <= cfg_wr_data[CFG_DIM_W-1:0];
                default: ;
            endcase
        end
    end

    abb_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .pop        (step),
        .item_valid (item_valid),
        .item_alpha (item_alpha)
    );

    abb_box_track u_track (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item_alpha (item_alpha),
        .out_free   (out_free),
        .step       (step),
        .res_valid  (res_valid),
        .res        (res)
    );

    abb_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (res_valid),
        .res      (res),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // A result only appears after a frame end reached the tracker
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(res_valid))
        else $error("result transaction without a frame end");

    // An empty frame reports its box from the origin
    a_empty_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[DIM_W-1:0] == '0 &&
                                    m_tdata[2*DIM_W-1:DIM_W] == '0))
        else $error("empty frame box does not start at the origin");

endmodule
